// ===== rtl/aae_pkg.sv =====
// Package for the ALU execute unit: operation codes, decoded item type, result type.
// No dependencies.
`timescale 1ns / 1ps
package aae_pkg;

  localparam int unsigned RegCount = 32;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [5:0] {
    OP_ADD = 6'd0, OP_ADC = 6'd1, OP_SUB = 6'd2, OP_SBC = 6'd3, OP_SUBI = 6'd4,
    OP_SBCI = 6'd5, OP_CP = 6'd6, OP_CPC = 6'd7, OP_CPI = 6'd8, OP_AND = 6'd9,
    OP_ANDI = 6'd10, OP_OR = 6'd11, OP_ORI = 6'd12, OP_EOR = 6'd13, OP_COM = 6'd14,
    OP_NEG = 6'd15, OP_INC = 6'd16, OP_DEC = 6'd17, OP_ASR = 6'd18, OP_LSR = 6'd19,
    OP_ROR = 6'd20, OP_ADIW = 6'd21, OP_SBIW = 6'd22, OP_MUL = 6'd23, OP_MULS = 6'd24,
    OP_MULSU = 6'd25, OP_FMUL = 6'd26, OP_FMULS = 6'd27, OP_FMULSU = 6'd28,
    OP_MOV = 6'd29, OP_MOVW = 6'd30, OP_LDI = 6'd31, OP_BSET = 6'd32, OP_BCLR = 6'd33,
    OP_BST = 6'd34, OP_BLD = 6'd35, OP_CPSE = 6'd36, OP_SBRC = 6'd37, OP_SBRS = 6'd38,
    OP_NOP = 6'd39
  } op_e;

  // Status register bit positions.
  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagV = 3;
  localparam int unsigned FlagS = 4;
  localparam int unsigned FlagH = 5;
  localparam int unsigned FlagT = 6;

  // Decoded instruction as it travels from the front part to the back part.
  typedef struct packed {
    op_e        op;
    logic [4:0] dest;
    logic [4:0] src;
    logic [7:0] imm;
    logic [2:0] bsel;
  } instr_t;

  typedef struct packed {
    logic       skip;
    logic [7:0] status;
    logic [7:0] hi;
    logic [7:0] lo;
  } result_t;

  // Map raw opcodes onto the enum; unused codes become a no-operation.
  function automatic op_e classify(input logic [5:0] kind);
    op_e op;
    op = (kind > 6'd38) ? OP_NOP : op_e'(kind);
    return op;
  endfunction

endpackage

// ===== rtl/avr_alu_execute_with_flags_unit.sv =====
// Top level of the ALU execute unit with status register.
// Depends on aae_pkg, aae_front and aae_back.
//
// Channel  Dir  Bits  Contents
// s_axis   in   32    kind, dest_reg, src_reg, immediate, bit_select
// m_axis   out  32    result_low, result_high, status_after, skip_next
//
// One request per cycle is accepted and one result per cycle retired while the output is not stalled.
// A request passes through the classify queue and then the registered execute stage.
// The execute stage reads and writes the register file in the same cycle,
// so back-to-back dependent requests need no forwarding.
// Reset clears all registers, the status register, the queue and the output register's valid flag.
// A stalled output holds its result; the two-entry queue buffers requests while the output stalls.
`timescale 1ns / 1ps
module avr_alu_execute_with_flags_unit #(
  parameter int unsigned QueueDepth = aae_pkg::QueueDepth,
  parameter int unsigned RegCount   = aae_pkg::RegCount
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [5:0] kind, [10:6] dest_reg, [15:11] src_reg, [23:16] immediate,
  // [26:24] bit_select, [31:27] zero
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] result_low, [15:8] result_high, [23:16] status_after,
  // [24] skip_next, [31:25] zero
  output logic [31:0] m_axis_tdata
);
  aae_pkg::instr_t  in_instr, q_instr;
  aae_pkg::result_t res;
  logic             q_valid, q_ready;

  assign in_instr.op   = aae_pkg::op_e'(s_axis_tdata[5:0]);
  assign in_instr.dest = s_axis_tdata[10:6];
  assign in_instr.src  = s_axis_tdata[15:11];
  assign in_instr.imm  = s_axis_tdata[23:16];
  assign in_instr.bsel = s_axis_tdata[26:24];

  aae_front #(.Depth(QueueDepth)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_instr_i(in_instr),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_instr_o(q_instr)
  );

  aae_back #(.Regs(RegCount)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_instr_i(q_instr),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {7'd0, res.skip, res.status, res.hi, res.lo};

  // A held result must not change while the sink stalls.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

  // Only skip instructions may request a skip, and they write nothing.
  a_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[24] |-> m_axis_tdata[15:0] == 16'd0)
    else $error("skip with written data");

  // The queue always reports ready while it is empty.
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_valid |-> s_axis_tready)
    else $error("empty queue not ready");
endmodule

// ===== rtl/aae_front.sv =====
// Front part: accepts requests, classifies the opcode and fills a short queue.
// Depends on aae_pkg.
`timescale 1ns / 1ps
module aae_front #(
  parameter int unsigned Depth = aae_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  aae_pkg::instr_t in_instr_i,
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output aae_pkg::instr_t q_instr_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  aae_pkg::instr_t slots_q [Depth];
  aae_pkg::instr_t in_class;
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            push, pop;

  assign in_ready_o = (cnt_q != (PtrW+1)'(Depth));
  assign q_valid_o  = (cnt_q != '0);
  assign q_instr_o  = slots_q[rd_q];
  assign push = in_valid_i & in_ready_o;
  assign pop  = q_valid_o & q_ready_i;

  // Classify the incoming opcode; unused codes become a no-operation.
  always_comb begin
    in_class    = in_instr_i;
    in_class.op = aae_pkg::classify(in_instr_i.op);
  end

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the classified request.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_q] <= in_class;
    end
  end
endmodule

// ===== rtl/aae_back.sv =====
// Back part: register file, status register and the ALU; one request per cycle while the output is not stalled.
// Depends on aae_pkg.
`timescale 1ns / 1ps
module aae_back #(
  parameter int unsigned Regs = aae_pkg::RegCount
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_ready_o,
  input  aae_pkg::instr_t  q_instr_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output aae_pkg::result_t res_o
);
  localparam int unsigned IdxW = $clog2(Regs);

  logic [7:0] rf_q [Regs];
  logic [7:0] sreg_q;
  logic       out_valid_q;
  aae_pkg::result_t out_q;

  aae_pkg::instr_t  ins;
  logic [7:0]  a, c, k, r, lo, hi, s, mask, opb;
  logic        cin, wr, pair, skip, keepz, oldz, sub_op, add_op, mul_op, frac;
  logic [7:0]  cy;
  logic [15:0] w, wres, prod, mres;
  logic [IdxW-1:0] pd, ps;
  logic signed [17:0] sprod;
  logic signed [8:0]  ma, mb;
  logic        fire;

  assign ins  = q_instr_i;
  assign q_ready_o = !out_valid_q || res_ready_i;
  assign fire = q_valid_i && q_ready_o;
  assign res_valid_o = out_valid_q;
  assign res_o = out_q;

  assign a   = rf_q[ins.dest[IdxW-1:0]];
  assign c   = rf_q[ins.src[IdxW-1:0]];
  assign k   = ins.imm;
  assign cin = sreg_q[aae_pkg::FlagC];
  assign pd  = {ins.dest[IdxW-1:1], 1'b0};
  assign ps  = {ins.src[IdxW-1:1], 1'b0};
  assign mask = 8'(1) << ins.bsel;

  // Execute: compute result bytes, flags and skip decision.
  always_comb begin
    s = sreg_q; lo = '0; hi = '0; wr = 1'b0; pair = 1'b0; skip = 1'b0;
    r = '0; cy = '0; w = '0; wres = '0; ma = '0; mb = '0; sprod = '0;
    prod = '0; mres = '0; frac = 1'b0; keepz = 1'b0; opb = c;
    oldz = sreg_q[aae_pkg::FlagZ];
    add_op = (ins.op == aae_pkg::OP_ADD) || (ins.op == aae_pkg::OP_ADC);
    sub_op = (ins.op inside {aae_pkg::OP_SUB, aae_pkg::OP_SBC, aae_pkg::OP_SUBI,
      aae_pkg::OP_SBCI, aae_pkg::OP_CP, aae_pkg::OP_CPC, aae_pkg::OP_CPI});
    mul_op = (ins.op inside {[aae_pkg::OP_MUL : aae_pkg::OP_FMULSU]});
    if (add_op) begin
      r  = a + c + {7'd0, (ins.op == aae_pkg::OP_ADC) & cin};
      cy = (a & c) | (c & ~r) | (~r & a);
      s[aae_pkg::FlagH] = cy[3];
      s[aae_pkg::FlagC] = cy[7];
      s[aae_pkg::FlagV] = (a[7] & c[7] & ~r[7]) | (~a[7] & ~c[7] & r[7]);
      s[aae_pkg::FlagN] = r[7];
      s[aae_pkg::FlagZ] = (r == 8'd0);
      lo = r; wr = 1'b1;
    end else if (sub_op) begin
      if (ins.op inside {aae_pkg::OP_SUBI, aae_pkg::OP_SBCI, aae_pkg::OP_CPI}) begin
        opb = k;
      end
      keepz = (ins.op inside {aae_pkg::OP_SBC, aae_pkg::OP_SBCI, aae_pkg::OP_CPC});
      r  = a - opb - {7'd0, keepz & cin};
      cy = (~a & opb) | (opb & r) | (r & ~a);
      s[aae_pkg::FlagH] = cy[3];
      s[aae_pkg::FlagC] = cy[7];
      s[aae_pkg::FlagV] = (a[7] & ~opb[7] & ~r[7]) | (~a[7] & opb[7] & r[7]);
      s[aae_pkg::FlagN] = r[7];
      s[aae_pkg::FlagZ] = (r == 8'd0) && (!keepz || oldz);
      lo = r;
      wr = !(ins.op inside {aae_pkg::OP_CP, aae_pkg::OP_CPC, aae_pkg::OP_CPI});
    end else if (mul_op) begin
      // Signed 9x9 product covers the unsigned, signed and mixed forms.
      ma = (ins.op inside {aae_pkg::OP_MUL, aae_pkg::OP_FMUL}) ?
           {1'b0, a} : {a[7], a};
      mb = (ins.op inside {aae_pkg::OP_MULS, aae_pkg::OP_FMULS}) ?
           {c[7], c} : {1'b0, c};
      sprod = ma * mb;
      prod  = sprod[15:0];
      frac  = (ins.op inside {aae_pkg::OP_FMUL, aae_pkg::OP_FMULS, aae_pkg::OP_FMULSU});
      mres  = frac ? {prod[14:0], 1'b0} : prod;
      s[aae_pkg::FlagC] = prod[15];
      s[aae_pkg::FlagZ] = (mres == 16'd0);
      lo = mres[7:0]; hi = mres[15:8];
    end else begin
      case (ins.op)
        aae_pkg::OP_AND, aae_pkg::OP_ANDI, aae_pkg::OP_OR, aae_pkg::OP_ORI,
        aae_pkg::OP_EOR, aae_pkg::OP_COM: begin
          case (ins.op)
            aae_pkg::OP_AND:  r = a & c;
            aae_pkg::OP_ANDI: r = a & k;
            aae_pkg::OP_OR:   r = a | c;
            aae_pkg::OP_ORI:  r = a | k;
            aae_pkg::OP_EOR:  r = a ^ c;
            default:          r = ~a;
          endcase
          s[aae_pkg::FlagN] = r[7];
          s[aae_pkg::FlagZ] = (r == 8'd0);
          s[aae_pkg::FlagV] = 1'b0;
          if (ins.op == aae_pkg::OP_COM) begin
            s[aae_pkg::FlagC] = 1'b1;
          end
          lo = r; wr = 1'b1;
        end
        aae_pkg::OP_NEG: begin
          r = 8'd0 - a;
          s[aae_pkg::FlagN] = r[7];
          s[aae_pkg::FlagZ] = (r == 8'd0);
          s[aae_pkg::FlagC] = (r != 8'd0);
          s[aae_pkg::FlagV] = (r == 8'h80);
          s[aae_pkg::FlagH] = r[3] | a[3];
          lo = r; wr = 1'b1;
        end
        aae_pkg::OP_INC, aae_pkg::OP_DEC: begin
          r = (ins.op == aae_pkg::OP_INC) ? a + 8'd1 : a - 8'd1;
          s[aae_pkg::FlagN] = r[7];
          s[aae_pkg::FlagZ] = (r == 8'd0);
          s[aae_pkg::FlagV] = (ins.op == aae_pkg::OP_INC) ? (r == 8'h80) : (r == 8'h7f);
          lo = r; wr = 1'b1;
        end
        aae_pkg::OP_ASR, aae_pkg::OP_LSR, aae_pkg::OP_ROR: begin
          case (ins.op)
            aae_pkg::OP_ASR: r = {a[7], a[7:1]};
            aae_pkg::OP_LSR: r = {1'b0, a[7:1]};
            default:         r = {cin, a[7:1]};
          endcase
          s[aae_pkg::FlagN] = r[7];
          s[aae_pkg::FlagZ] = (r == 8'd0);
          s[aae_pkg::FlagC] = a[0];
          s[aae_pkg::FlagV] = r[7] ^ a[0];
          lo = r; wr = 1'b1;
        end
        aae_pkg::OP_ADIW, aae_pkg::OP_SBIW: begin
          w = {rf_q[pd + 1'b1], rf_q[pd]};
          wres = (ins.op == aae_pkg::OP_ADIW) ? w + {10'd0, k[5:0]} : w - {10'd0, k[5:0]};
          s[aae_pkg::FlagN] = wres[15];
          s[aae_pkg::FlagZ] = (wres == 16'd0);
          if (ins.op == aae_pkg::OP_ADIW) begin
            s[aae_pkg::FlagV] = ~w[15] & wres[15];
            s[aae_pkg::FlagC] = ~wres[15] & w[15];
          end else begin
            s[aae_pkg::FlagV] = w[15] & ~wres[15];
            s[aae_pkg::FlagC] = wres[15] & ~w[15];
          end
          lo = wres[7:0]; hi = wres[15:8]; pair = 1'b1;
        end
        aae_pkg::OP_MOV: begin lo = c; wr = 1'b1; end
        aae_pkg::OP_MOVW: begin
          lo = rf_q[ps]; hi = rf_q[ps + 1'b1]; pair = 1'b1;
        end
        aae_pkg::OP_LDI:  begin lo = k; wr = 1'b1; end
        aae_pkg::OP_BSET: s = sreg_q | mask;
        aae_pkg::OP_BCLR: s = sreg_q & ~mask;
        aae_pkg::OP_BST:  s[aae_pkg::FlagT] = a[ins.bsel];
        aae_pkg::OP_BLD: begin
          lo = sreg_q[aae_pkg::FlagT] ? (a | mask) : (a & ~mask);
          wr = 1'b1;
        end
        aae_pkg::OP_CPSE: skip = (a == c);
        aae_pkg::OP_SBRC: skip = !a[ins.bsel];
        aae_pkg::OP_SBRS: skip = a[ins.bsel];
        default: ;
      endcase
    end
    // Sign flag follows N and V only for the arithmetic, logic, shift and word opcodes.
    if (ins.op inside {[aae_pkg::OP_ADD : aae_pkg::OP_SBIW]}) begin
      s[aae_pkg::FlagS] = s[aae_pkg::FlagN] ^ s[aae_pkg::FlagV];
    end
  end

  // Architectural state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Regs; i++) begin
        rf_q[i] <= '0;
      end
      sreg_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        sreg_q <= s;
        if (mul_op) begin
          rf_q[0] <= lo;
          rf_q[1] <= hi;
        end else if (pair) begin
          rf_q[pd]        <= lo;
          rf_q[pd + 1'b1] <= hi;
        end else if (wr) begin
          rf_q[ins.dest[IdxW-1:0]] <= lo;
        end
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.lo     <= (wr || pair || mul_op) ? lo : 8'd0;
      out_q.hi     <= hi;
      out_q.status <= s;
      out_q.skip   <= skip;
    end
  end
endmodule

// ===== tb/sv/tb_avr_alu_execute_with_flags_unit.sv =====
// Self-checking testbench for the ALU execute unit with status register.
// Depends on aae_pkg and the avr_alu_execute_with_flags_unit RTL; predicts every result in place.
`timescale 1ns / 1ps
module tb_avr_alu_execute_with_flags_unit;
  import aae_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [5:0] kind, [10:6] dest_reg, [15:11] src_reg, [23:16] immediate, [26:24] bit_select
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [7:0] result_low, [15:8] result_high, [23:16] status_after, [24] skip_next
  logic [31:0] m_axis_tdata;

  avr_alu_execute_with_flags_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // Clock with a 12 ns period.
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [31:0] pending_requests[$];
  result_t     expected_results[$];
  logic [7:0]  gpr[32];
  logic [7:0]  sreg;
  int          errors = 0;
  int          results_seen = 0;
  int          cycle_count = 0;
  bit          stimulus_done = 1'b0;
  int          send_gap = 0;
  int          recv_gap = 0;

  // Random gap length: mostly zero or short, sometimes long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] with_s(logic [7:0] s);
    s[FlagS] = s[FlagN] ^ s[FlagV];
    return s;
  endfunction

  function automatic logic [7:0] with_nz(logic [7:0] s, logic [7:0] r);
    s[FlagN] = r[7];
    s[FlagZ] = (r == 8'h00);
    return s;
  endfunction

  // Add with carry in; updates sreg and returns the sum byte.
  function automatic logic [7:0] add_byte(logic [7:0] a, logic [7:0] b, logic cin);
    logic [7:0] r, cy;
    r = a + b + cin;
    cy = (a & b) | (b & ~r) | (~r & a);
    sreg[FlagH] = cy[3];
    sreg[FlagC] = cy[7];
    sreg[FlagV] = (a[7] & b[7] & ~r[7]) | (~a[7] & ~b[7] & r[7]);
    sreg = with_s(with_nz(sreg, r));
    return r;
  endfunction

  // Subtract with borrow in; carry forms keep Z only across a zero result.
  function automatic logic [7:0] sub_byte(logic [7:0] a, logic [7:0] b, logic cin,
                                          logic keepz);
    logic [7:0] r, bw;
    logic       oldz;
    r = a - b - cin;
    bw = (~a & b) | (b & r) | (r & ~a);
    oldz = sreg[FlagZ];
    sreg[FlagH] = bw[3];
    sreg[FlagC] = bw[7];
    sreg[FlagV] = (a[7] & ~b[7] & ~r[7]) | (~a[7] & b[7] & r[7]);
    sreg = with_nz(sreg, r);
    if (keepz) sreg[FlagZ] = (r == 8'h00) && oldz;
    sreg = with_s(sreg);
    return r;
  endfunction

  function automatic logic [7:0] logic_byte(logic [7:0] r);
    sreg = with_nz(sreg, r);
    sreg[FlagV] = 1'b0;
    sreg = with_s(sreg);
    return r;
  endfunction

  function automatic logic [7:0] shift_byte(logic [7:0] a, logic [7:0] r);
    sreg = with_nz(sreg, r);
    sreg[FlagC] = a[0];
    sreg[FlagV] = r[7] ^ a[0];
    sreg = with_s(sreg);
    return r;
  endfunction

  // Multiply into r1:r0; the fractional forms shift left by one.
  function automatic void mul_pair(logic signed [17:0] p, logic frac);
    logic [15:0] prod, r;
    prod = p[15:0];
    r = frac ? {prod[14:0], 1'b0} : prod;
    sreg[FlagC] = prod[15];
    sreg[FlagZ] = (r == 16'h0000);
    gpr[0] = r[7:0];
    gpr[1] = r[15:8];
  endfunction

  // Executes one request against the shadow state and returns its result.
  function automatic result_t execute_instr(logic [31:0] req);
    result_t     res;
    op_e         op;
    logic [4:0]  d, rr, pd, ps;
    logic [7:0]  k, a, c, lo, hi, t;
    logic [2:0]  b;
    logic        cin, wr, pair, skip;
    logic [15:0] w, wres;
    op = classify(req[5:0]);
    d = req[10:6];
    rr = req[15:11];
    k = req[23:16];
    b = req[26:24];
    a = gpr[d];
    c = gpr[rr];
    cin = sreg[FlagC];
    pd = {d[4:1], 1'b0};
    ps = {rr[4:1], 1'b0};
    lo = 8'h00;
    hi = 8'h00;
    wr = 1'b1;
    pair = 1'b0;
    skip = 1'b0;
    case (op)
      OP_ADD:  lo = add_byte(a, c, 1'b0);
      OP_ADC:  lo = add_byte(a, c, cin);
      OP_SUB:  lo = sub_byte(a, c, 1'b0, 1'b0);
      OP_SBC:  lo = sub_byte(a, c, cin, 1'b1);
      OP_SUBI: lo = sub_byte(a, k, 1'b0, 1'b0);
      OP_SBCI: lo = sub_byte(a, k, cin, 1'b1);
      OP_CP: begin
        t = sub_byte(a, c, 1'b0, 1'b0);
        wr = 1'b0;
      end
      OP_CPC: begin
        t = sub_byte(a, c, cin, 1'b1);
        wr = 1'b0;
      end
      OP_CPI: begin
        t = sub_byte(a, k, 1'b0, 1'b0);
        wr = 1'b0;
      end
      OP_AND:  lo = logic_byte(a & c);
      OP_ANDI: lo = logic_byte(a & k);
      OP_OR:   lo = logic_byte(a | c);
      OP_ORI:  lo = logic_byte(a | k);
      OP_EOR:  lo = logic_byte(a ^ c);
      OP_COM: begin
        lo = logic_byte(~a);
        sreg[FlagC] = 1'b1;
      end
      OP_NEG: begin
        lo = 8'h00 - a;
        sreg = with_nz(sreg, lo);
        sreg[FlagC] = (lo != 8'h00);
        sreg[FlagV] = (lo == 8'h80);
        sreg[FlagH] = lo[3] | a[3];
        sreg = with_s(sreg);
      end
      OP_INC: begin
        lo = a + 8'd1;
        sreg = with_nz(sreg, lo);
        sreg[FlagV] = (lo == 8'h80);
        sreg = with_s(sreg);
      end
      OP_DEC: begin
        lo = a - 8'd1;
        sreg = with_nz(sreg, lo);
        sreg[FlagV] = (lo == 8'h7f);
        sreg = with_s(sreg);
      end
      OP_ASR: lo = shift_byte(a, {a[7], a[7:1]});
      OP_LSR: lo = shift_byte(a, {1'b0, a[7:1]});
      OP_ROR: lo = shift_byte(a, {cin, a[7:1]});
      OP_ADIW, OP_SBIW: begin
        w = {gpr[pd + 5'd1], gpr[pd]};
        wres = (op == OP_ADIW) ? w + k[5:0] : w - k[5:0];
        sreg[FlagN] = wres[15];
        sreg[FlagZ] = (wres == 16'h0000);
        if (op == OP_ADIW) begin
          sreg[FlagV] = ~w[15] & wres[15];
          sreg[FlagC] = ~wres[15] & w[15];
        end else begin
          sreg[FlagV] = w[15] & ~wres[15];
          sreg[FlagC] = wres[15] & ~w[15];
        end
        sreg = with_s(sreg);
        {hi, lo} = wres;
        pair = 1'b1;
      end
      OP_MUL:    mul_pair($signed({10'd0, a}) * $signed({10'd0, c}), 1'b0);
      OP_MULS:   mul_pair($signed({{10{a[7]}}, a}) * $signed({{10{c[7]}}, c}), 1'b0);
      OP_MULSU:  mul_pair($signed({{10{a[7]}}, a}) * $signed({10'd0, c}), 1'b0);
      OP_FMUL:   mul_pair($signed({10'd0, a}) * $signed({10'd0, c}), 1'b1);
      OP_FMULS:  mul_pair($signed({{10{a[7]}}, a}) * $signed({{10{c[7]}}, c}), 1'b1);
      OP_FMULSU: mul_pair($signed({{10{a[7]}}, a}) * $signed({10'd0, c}), 1'b1);
      OP_MOV: lo = c;
      OP_MOVW: begin
        lo = gpr[ps];
        hi = gpr[ps + 5'd1];
        pair = 1'b1;
      end
      OP_LDI: lo = k;
      OP_BSET: begin
        sreg[b] = 1'b1;
        wr = 1'b0;
      end
      OP_BCLR: begin
        sreg[b] = 1'b0;
        wr = 1'b0;
      end
      OP_BST: begin
        sreg[FlagT] = a[b];
        wr = 1'b0;
      end
      OP_BLD: begin
        lo = a;
        lo[b] = sreg[FlagT];
      end
      OP_CPSE: begin
        skip = (a == c);
        wr = 1'b0;
      end
      OP_SBRC: begin
        skip = ~a[b];
        wr = 1'b0;
      end
      OP_SBRS: begin
        skip = a[b];
        wr = 1'b0;
      end
      default: wr = 1'b0;
    endcase
    // Write back: multiplies report r1:r0, pairs write both bytes.
    if (op inside {OP_MUL, OP_MULS, OP_MULSU, OP_FMUL, OP_FMULS, OP_FMULSU}) begin
      lo = gpr[0];
      hi = gpr[1];
    end else if (pair) begin
      gpr[pd] = lo;
      gpr[pd + 5'd1] = hi;
    end else if (wr) begin
      gpr[d] = lo;
    end else begin
      lo = 8'h00;
    end
    res.lo = lo;
    res.hi = hi;
    res.status = sreg;
    res.skip = skip;
    return res;
  endfunction

  function automatic logic [31:0] pack_instr(logic [5:0] kind, logic [4:0] d, logic [4:0] r,
                                             logic [7:0] k, logic [2:0] b);
    return {5'd0, b, k, r, d, kind};
  endfunction

  // Random request: most are valid operations, a few are unused codes.
  function automatic logic [31:0] random_instr();
    logic [5:0] kind;
    logic [4:0] d;
    if ($urandom_range(0, 19) == 0) kind = $urandom_range(39, 63);
    else kind = $urandom_range(0, 38);
    // Favor a handful of registers so results feed later operations.
    d = ($urandom_range(0, 2) == 0) ? 5'($urandom) : 5'($urandom_range(0, 5));
    return pack_instr(kind, d,
                      ($urandom_range(0, 2) == 0) ? 5'($urandom) : 5'($urandom_range(0, 5)),
                      8'($urandom), 3'($urandom));
  endfunction

  // Directed part, then random requests.
  initial begin
    logic [7:0] edge_vals[6];
    edge_vals = '{8'h00, 8'h7f, 8'h80, 8'hff, 8'h01, 8'h08};
    // Load extreme values into low registers, then run every operation once.
    foreach (edge_vals[i])
      pending_requests.push_back(pack_instr(OP_LDI, 5'(i), 5'd0, edge_vals[i], 3'd0));
    pending_requests.push_back(pack_instr(OP_LDI, 5'd31, 5'd0, 8'hff, 3'd0));
    pending_requests.push_back(pack_instr(OP_LDI, 5'd30, 5'd0, 8'hff, 3'd0));
    for (int op = 0; op <= 38; op++)
      pending_requests.push_back(pack_instr(6'(op), 5'(op % 6), 5'((op + 2) % 6),
                                            8'hff, 3'(op)));
    // Word add wrapping at the top pair, carry compare on zero, unused code, multiply.
    pending_requests.push_back(pack_instr(OP_ADIW, 5'd31, 5'd0, 8'hff, 3'd7));
    pending_requests.push_back(pack_instr(OP_CPC, 5'd0, 5'd0, 8'h00, 3'd0));
    pending_requests.push_back(pack_instr(6'd63, 5'd31, 5'd31, 8'hff, 3'd7));
    pending_requests.push_back(pack_instr(OP_MUL, 5'd0, 5'd1, 8'h00, 3'd0));
    for (int i = 0; i < 1550; i++) pending_requests.push_back(random_instr());
  end

  // Reset and driver.
  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    for (int i = 0; i < 32; i++) gpr[i] = 8'h00;
    sreg = 8'h00;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(execute_instr(s_axis_tdata));
        send_gap = pick_gap();
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0 || pending_requests.size() == 0) begin
          if (send_gap > 0) send_gap--;
          s_axis_tvalid <= 1'b0;
          if (pending_requests.size() == 0 && !(s_axis_tvalid && !s_axis_tready))
            stimulus_done = 1'b1;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_requests.pop_front();
        end
      end
    end
  end

  // Monitor with random output stalls.
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[24:0];
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result %h", m_axis_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.lo !== want.lo) begin
            $error("result_low expected %h got %h", want.lo, got.lo);
            errors++;
          end
          if (got.hi !== want.hi) begin
            $error("result_high expected %h got %h", want.hi, got.hi);
            errors++;
          end
          if (got.status !== want.status) begin
            $error("status_after expected %h got %h", want.status, got.status);
            errors++;
          end
          if (got.skip !== want.skip) begin
            $error("skip_next expected %b got %b", want.skip, got.skip);
            errors++;
          end
          if (m_axis_tdata[31:25] !== 7'd0) begin
            $error("tdata pad expected 0 got %h", m_axis_tdata[31:25]);
            errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        recv_gap = pick_gap();
        m_axis_tready <= 1'b1;
      end
    end
  end

  // End of run: drain, settle, report.
  initial begin
    wait (rst_ni && stimulus_done && expected_results.size() == 0 && !s_axis_tvalid);
    repeat (20) @(posedge clk_i);
    $display("Ran %0d checked results covering every operation, unused codes and stalls.",
             results_seen);
    if (errors == 0 && expected_results.size() == 0)
      $display("tb_avr_alu_execute_with_flags_unit: PASS");
    else
      $display("tb_avr_alu_execute_with_flags_unit: FAIL");
    $finish;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("tb_avr_alu_execute_with_flags_unit: FAIL");
      $finish;
    end
  end

endmodule
